>>> rtl/windowed_trial_sample_store_defines.svh
// Assertion macros shared by the sample store RTL.
`ifndef WINDOWED_TRIAL_SAMPLE_STORE_DEFINES_SVH
`define WINDOWED_TRIAL_SAMPLE_STORE_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define WTSS_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("windowed_trial_sample_store: check failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define WTSS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("windowed_trial_sample_store: check failed");

`endif

>>> rtl/wtss_pkg.sv
// Shared constants, codes and types of the windowed trial sample store.
package wtss_pkg;

   localparam int TRIALS      = 8;
   localparam int SAMPLES     = 256;
   localparam int SLOT_W      = $clog2(TRIALS);
   localparam int IDX_W       = $clog2(SAMPLES);
   localparam int ADDR_W      = SLOT_W + IDX_W;
   localparam int MEM_DEPTH   = TRIALS * SAMPLES;
   localparam int COUNT_W     = $clog2(SAMPLES + 1);
   localparam int HELD_W      = $clog2(TRIALS + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int KIND_W      = 3;
   localparam int REQ_DATA_W  = 80;
   localparam int RSP_DATA_W  = 120;

   localparam logic [KIND_W-1:0] KIND_NEW_RUN  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_APPEND   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_READ_CUR = 3'd3;
   localparam logic [KIND_W-1:0] KIND_READ_RUN = 3'd4;

   typedef struct packed {
      logic               mem_we;
      logic               mem_re;
      logic [ADDR_W-1:0]  addr;
      logic [31:0]        wr_time;
      logic [31:0]        wr_value;
      logic               ok;
      logic [31:0]        run_number;
      logic [COUNT_W-1:0] run_samples;
      logic [COUNT_W-1:0] current_samples;
      logic [HELD_W-1:0]  stored_runs;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

>>> rtl/wtss_front.sv
// Front part: takes request beats, keeps the run bookkeeping and issues memory commands.
module wtss_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [wtss_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [wtss_pkg::KIND_W-1:0]        req_tuser,
   input  wtss_pkg::qstat_type                q_status,
   output logic                               push,
   output wtss_pkg::cmd_type                  cmd
);
   import wtss_pkg::*;

   logic [SLOT_W-1:0]  oldest_ff, oldest_in;
   logic [SLOT_W-1:0]  active_ff, active_in;
   logic [HELD_W-1:0]  held_ff, held_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [31:0]        next_num_ff, next_num_in;
   logic [COUNT_W-1:0] run_counts_ff [TRIALS];
   logic [31:0]        run_numbers_ff [TRIALS];

   logic [31:0]        f_time;
   logic [31:0]        f_value;
   logic [SLOT_W-1:0]  f_run;
   logic [IDX_W-1:0]   f_sample;
   logic               cnt_we;
   logic [COUNT_W-1:0] cnt_wdata;
   logic               num_we;
   logic [SLOT_W-1:0]  rd_slot;

   assign f_time     = req_tdata[31:0];
   assign f_value    = req_tdata[63:32];
   assign f_run      = req_tdata[64 +: SLOT_W];
   assign f_sample   = req_tdata[67 +: IDX_W];
   assign req_tready = !q_status.full;
   assign push       = req_tvalid && !q_status.full;

   always_comb begin
      oldest_in   = oldest_ff;
      active_in   = active_ff;
      held_in     = held_ff;
      count_in    = count_ff;
      next_num_in = next_num_ff;
      cnt_we      = 1'b0;
      cnt_wdata   = '0;
      num_we      = 1'b0;
      rd_slot     = oldest_ff + f_run;
      cmd         = '0;
      cmd.wr_time  = f_time;
      cmd.wr_value = f_value;
      cmd.addr     = {active_ff, f_sample};
      case (req_tuser)
         KIND_NEW_RUN: begin
            if (held_ff >= HELD_W'(TRIALS)) begin
               active_in = oldest_ff;
               oldest_in = oldest_ff + SLOT_W'(1);
            end else begin
               active_in = oldest_ff + held_ff[SLOT_W-1:0];
               held_in   = held_ff + HELD_W'(1);
            end
            count_in    = '0;
            cnt_we      = 1'b1;
            num_we      = 1'b1;
            next_num_in = next_num_ff + 32'd1;
            cmd.ok      = 1'b1;
         end
         KIND_CLEAR: begin
            count_in = '0;
            cmd.ok   = 1'b1;
         end
         KIND_APPEND: begin
            if (count_ff < COUNT_W'(SAMPLES)) begin
               cmd.mem_we = 1'b1;
               cmd.addr   = {active_ff, count_ff[IDX_W-1:0]};
               count_in   = count_ff + COUNT_W'(1);
               cnt_we     = 1'b1;
               cnt_wdata  = count_ff + COUNT_W'(1);
               cmd.ok     = 1'b1;
            end
         end
         KIND_READ_CUR: begin
            if (COUNT_W'(f_sample) < count_ff) begin
               cmd.mem_re = 1'b1;
               cmd.ok     = 1'b1;
            end
         end
         KIND_READ_RUN: begin
            if (HELD_W'(f_run) < held_ff) begin
               cmd.run_number  = run_numbers_ff[rd_slot];
               cmd.run_samples = run_counts_ff[rd_slot];
               cmd.addr        = {rd_slot, f_sample};
               if (COUNT_W'(f_sample) < run_counts_ff[rd_slot]) begin
                  cmd.mem_re = 1'b1;
                  cmd.ok     = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      if (req_tuser != KIND_READ_RUN && held_in != '0) begin
         cmd.run_number  = num_we ? next_num_ff : run_numbers_ff[active_in];
         cmd.run_samples = cnt_we ? cnt_wdata : run_counts_ff[active_in];
      end
      cmd.current_samples = count_in;
      cmd.stored_runs     = held_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff   <= '0;
         active_ff   <= '0;
         held_ff     <= '0;
         count_ff    <= '0;
         next_num_ff <= 32'd1;
      end else if (push) begin
         oldest_ff   <= oldest_in;
         active_ff   <= active_in;
         held_ff     <= held_in;
         count_ff    <= count_in;
         next_num_ff <= next_num_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && cnt_we) begin
         run_counts_ff[active_in] <= cnt_wdata;
      end
      if (push && num_we) begin
         run_numbers_ff[active_in] <= next_num_ff;
      end
   end

endmodule

>>> rtl/wtss_queue.sv
// Short command queue between the front and back parts.
module wtss_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  wtss_pkg::cmd_type    push_cmd,
   input  logic                 pop,
   output wtss_pkg::cmd_type    head_cmd,
   output wtss_pkg::qstat_type  q_status
);
   import wtss_pkg::*;

   cmd_type             slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign head_cmd       = slots_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/wtss_back.sv
// Back part: sample memories and the result register.
module wtss_back (
   input  logic                             clock,
   input  logic                             reset,
   input  wtss_pkg::cmd_type                head_cmd,
   input  wtss_pkg::qstat_type              q_status,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [wtss_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import wtss_pkg::*;

   logic [31:0] time_mem  [MEM_DEPTH];
   logic [31:0] value_mem [MEM_DEPTH];
   logic [31:0] rd_time_ff;
   logic [31:0] rd_value_ff;
   cmd_type     meta_ff;
   logic        valid_ff;
   logic [31:0] out_time;
   logic [31:0] out_value;

   assign pop        = !q_status.empty && (!valid_ff || rsp_tready);
   assign rsp_tvalid = valid_ff;
   assign out_time   = meta_ff.mem_re ? rd_time_ff : 32'd0;
   assign out_value  = meta_ff.mem_re ? rd_value_ff : 32'd0;
   assign rsp_tdata  = {1'b0, meta_ff.stored_runs, meta_ff.current_samples,
                        meta_ff.run_samples, meta_ff.run_number, out_value,
                        out_time, meta_ff.ok};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         meta_ff <= head_cmd;
         if (head_cmd.mem_we) begin
            time_mem[head_cmd.addr]  <= head_cmd.wr_time;
            value_mem[head_cmd.addr] <= head_cmd.wr_value;
         end
         if (head_cmd.mem_re) begin
            rd_time_ff  <= time_mem[head_cmd.addr];
            rd_value_ff <= value_mem[head_cmd.addr];
         end
      end
   end

endmodule

>>> rtl/windowed_trial_sample_store.sv
// Top level of the windowed trial sample store: front, command queue and back.
//
// Channel   Dir  Payload
// req_*     in   tuser: kind; tdata: time_ms, raw_value, run_index, sample_index
// rsp_*     out  tdata: ok, time_out, value_out, run_number, run_samples,
//                current_samples, stored_runs
//
// One beat per cycle is sustained while the result side is ready; a result passes
// through the command queue and then the registered sample memory read.
// Reset is synchronous and clears all control state; memory contents stay undefined.
// A stalled result holds the back part; the two-entry queue then fills and stalls
// the request side.
module windowed_trial_sample_store (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // time_ms[31:0], raw_value[63:32], run_index[66:64], sample_index[74:67]
   input  logic [wtss_pkg::REQ_DATA_W-1:0]  req_tdata,
   // kind[2:0]
   input  logic [wtss_pkg::KIND_W-1:0]      req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // ok[0], time_out[32:1], value_out[64:33], run_number[96:65],
   // run_samples[105:97], current_samples[114:106], stored_runs[118:115]
   output logic [wtss_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import wtss_pkg::*;
   `include "windowed_trial_sample_store_defines.svh"

   cmd_type   push_cmd;
   cmd_type   head_cmd;
   qstat_type q_status;
   logic      push;
   logic      pop;

   wtss_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_status   (q_status),
      .push       (push),
      .cmd        (push_cmd)
   );

   wtss_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_status (q_status)
   );

   wtss_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   `WTSS_ASSERT_IMP(a_zero_data_when_not_ok, rsp_tvalid && !rsp_tdata[0], rsp_tdata[64:1] == 64'd0)
   `WTSS_ASSERT_IMP(a_stored_runs_bound, rsp_tvalid, rsp_tdata[118:115] <= 4'd8)
   `WTSS_ASSERT_IMP(a_current_bound, rsp_tvalid, rsp_tdata[114:106] <= 9'd256)
   `WTSS_ASSERT_NEXT(a_push_lands, push, !q_status.empty)

endmodule

>>> bench/tb.sv
// Self-checking bench for the windowed trial sample store with a stream driver and monitor.
module tb;
   import wtss_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
   localparam logic [KIND_W-1:0] KIND_UNUSED_LAST  = 3'd7;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_BEATS  = 560;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [31:0]       time_ms;
      logic signed [31:0] raw_value;
      logic [SLOT_W-1:0] run_index;
      logic [IDX_W-1:0]  sample_index;
   } store_op_type;

   typedef struct packed {
      logic               ok;
      logic [31:0]        time_out;
      logic signed [31:0] value_out;
      logic [31:0]        run_number;
      logic [COUNT_W-1:0] run_samples;
      logic [COUNT_W-1:0] current_samples;
      logic [HELD_W-1:0]  stored_runs;
   } store_result_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // time_ms[31:0], raw_value[63:32], run_index[66:64], sample_index[74:67]
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // kind[2:0]
   logic [KIND_W-1:0]     req_tuser = KIND_NEW_RUN;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // ok[0], time_out[32:1], value_out[64:33], run_number[96:65],
   // run_samples[105:97], current_samples[114:106], stored_runs[118:115]
   logic [RSP_DATA_W-1:0] rsp_tdata;

   windowed_trial_sample_store dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Shadow copy of the store.
   logic [31:0]        sample_times  [MEM_DEPTH];
   logic [31:0]        sample_values [MEM_DEPTH];
   logic [COUNT_W-1:0] slot_counts   [TRIALS];
   logic [31:0]        slot_seqs     [TRIALS];
   logic [SLOT_W-1:0]  ring_oldest = '0;
   logic [SLOT_W-1:0]  live_slot   = '0;
   int unsigned        held_runs   = 0;
   int unsigned        live_count  = 0;
   logic [31:0]        next_seq    = 32'd1;

   store_op_type     pending_ops[$];
   store_result_type expected_results[$];
   store_op_type     offered_op;

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int hold_orders = 0;
   int hold_served = 0;
   int rx_hold_left = 0;
   int ops_queued = 0;
   int gen_count = 0;
   int gen_runs = 0;
   int mismatches = 0;
   int results_checked = 0;
   int cycle_count = 0;
   int beats_by_kind [8] = '{default: 0};
   int good_reads = 0;
   int full_rejects = 0;
   int window_reuses = 0;

   function automatic store_result_type predict_store(store_op_type op);
      store_result_type r;
      logic [SLOT_W-1:0] slot;
      logic [ADDR_W-1:0] addr;
      r = '0;
      beats_by_kind[op.kind]++;
      case (op.kind)
         KIND_NEW_RUN: begin
            if (held_runs >= TRIALS) begin
               live_slot = ring_oldest;
               ring_oldest = ring_oldest + SLOT_W'(1);
               window_reuses++;
            end else begin
               live_slot = ring_oldest + SLOT_W'(held_runs);
               held_runs++;
            end
            live_count = 0;
            slot_counts[live_slot] = '0;
            slot_seqs[live_slot] = next_seq;
            next_seq = next_seq + 32'd1;
            r.ok = 1'b1;
         end
         KIND_CLEAR: begin
            live_count = 0;
            r.ok = 1'b1;
         end
         KIND_APPEND: begin
            if (live_count < SAMPLES) begin
               addr = {live_slot, IDX_W'(live_count)};
               sample_times[addr] = op.time_ms;
               sample_values[addr] = op.raw_value;
               live_count++;
               slot_counts[live_slot] = COUNT_W'(live_count);
               r.ok = 1'b1;
            end else begin
               full_rejects++;
            end
         end
         default: ;
      endcase
      if (op.kind == KIND_READ_RUN) begin
         if (op.run_index < held_runs) begin
            slot = ring_oldest + op.run_index;
            r.run_number = slot_seqs[slot];
            r.run_samples = slot_counts[slot];
            if (op.sample_index < slot_counts[slot] && op.sample_index < SAMPLES) begin
               addr = {slot, op.sample_index};
               r.ok = 1'b1;
               r.time_out = sample_times[addr];
               r.value_out = sample_values[addr];
            end
         end
      end else begin
         if (held_runs > 0) begin
            r.run_number = slot_seqs[live_slot];
            r.run_samples = slot_counts[live_slot];
         end
         if (op.kind == KIND_READ_CUR && op.sample_index < live_count
             && op.sample_index < SAMPLES) begin
            addr = {live_slot, op.sample_index};
            r.ok = 1'b1;
            r.time_out = sample_times[addr];
            r.value_out = sample_values[addr];
         end
      end
      if ((op.kind == KIND_READ_CUR || op.kind == KIND_READ_RUN) && r.ok) good_reads++;
      r.current_samples = COUNT_W'(live_count);
      r.stored_runs = HELD_W'(held_runs);
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] seen);
      if (want !== seen) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("Mismatch in %s at cycle %0d: expected %h, got %h",
                     name, cycle_count, want, seen);
      end
   endtask

   task automatic check_result(input logic [RSP_DATA_W-1:0] beat);
      store_result_type want;
      if (expected_results.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("Result beat with nothing expected at cycle %0d: %h", cycle_count, beat);
      end else begin
         want = expected_results.pop_front();
         results_checked++;
         compare_field("ok", 32'(want.ok), 32'(beat[0]));
         compare_field("time_out", want.time_out, beat[32:1]);
         compare_field("value_out", want.value_out, beat[64:33]);
         compare_field("run_number", want.run_number, beat[96:65]);
         compare_field("run_samples", 32'(want.run_samples), 32'(beat[105:97]));
         compare_field("current_samples", 32'(want.current_samples), 32'(beat[114:106]));
         compare_field("stored_runs", 32'(want.stored_runs), 32'(beat[118:115]));
      end
   endtask

   // Request driver: the prediction is made when a beat is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(predict_store(offered_op));
         end
         if (!req_tvalid || req_tready) begin
            if (pending_ops.size() > 0 && $urandom_range(99, 0) >= tx_idle_pct) begin
               offered_op = pending_ops.pop_front();
               req_tuser <= offered_op.kind;
               req_tdata <= REQ_DATA_W'({offered_op.sample_index, offered_op.run_index,
                                         offered_op.raw_value, offered_op.time_ms});
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor with random back-pressure and ordered long holds.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result(rsp_tdata);
         if (hold_served != hold_orders) begin
            hold_served <= hold_orders;
            rx_hold_left <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (rx_hold_left > 0) begin
            rx_hold_left <= rx_hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still expected",
                  cycle_count, expected_results.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic queue_op(input logic [KIND_W-1:0] kind, input logic [31:0] t,
                           input logic [31:0] v, input int ridx, input int sidx);
      store_op_type op;
      op.kind = kind;
      op.time_ms = t;
      op.raw_value = v;
      op.run_index = SLOT_W'(ridx);
      op.sample_index = IDX_W'(sidx);
      pending_ops.push_back(op);
      ops_queued++;
   endtask

   // One run: start it, then a mix of appends, reads, clears and unused kinds.
   task automatic queue_session();
      int appends_left;
      int extra;
      int app_pct;
      int pick;
      int sidx;
      queue_op(KIND_NEW_RUN, $urandom, $urandom, $urandom_range(7, 0), $urandom_range(255, 0));
      if (gen_runs < TRIALS) gen_runs++;
      gen_count = 0;
      if ($urandom_range(59, 0) == 0) begin
         appends_left = SAMPLES + $urandom_range(3, 1);
         app_pct = 95;
      end else begin
         appends_left = $urandom_range(24, 0);
         app_pct = 60;
      end
      extra = $urandom_range(12, 2);
      while (appends_left > 0 || extra > 0) begin
         if (appends_left > 0 && $urandom_range(99, 0) < app_pct) begin
            queue_op(KIND_APPEND, $urandom, $urandom, $urandom_range(7, 0),
                     $urandom_range(255, 0));
            appends_left--;
            if (gen_count < SAMPLES) gen_count++;
         end else begin
            if (extra > 0) extra--;
            pick = $urandom_range(99, 0);
            if (pick < 45) begin
               sidx = ($urandom_range(7, 0) == 0) ? $urandom_range(255, 0)
                                                 : $urandom_range(gen_count, 0);
               if (sidx > 255) sidx = 255;
               queue_op(KIND_READ_CUR, $urandom, $urandom, $urandom_range(7, 0), sidx);
            end else if (pick < 85) begin
               sidx = ($urandom_range(5, 0) == 0) ? $urandom_range(255, 0)
                                                 : $urandom_range(30, 0);
               queue_op(KIND_READ_RUN, $urandom, $urandom, $urandom_range(gen_runs, 0), sidx);
            end else if (pick < 93) begin
               queue_op(KIND_CLEAR, $urandom, $urandom, $urandom_range(7, 0),
                        $urandom_range(255, 0));
               gen_count = 0;
            end else begin
               queue_op(KIND_W'($urandom_range(KIND_UNUSED_LAST, KIND_UNUSED_FIRST)),
                        $urandom, $urandom, $urandom_range(7, 0), $urandom_range(255, 0));
            end
         end
      end
      if (gen_count == SAMPLES) begin
         queue_op(KIND_READ_CUR, $urandom, $urandom, 0, SAMPLES - 1);
         queue_op(KIND_READ_RUN, $urandom, $urandom, gen_runs - 1, SAMPLES - 1);
      end
   endtask

   task automatic run_phase(input int beats, input bit with_hold);
      int first;
      bit hold_done;
      first = ops_queued;
      hold_done = 1'b0;
      while (ops_queued - first < beats) begin
         while (pending_ops.size() > 16) @(negedge clock);
         if (with_hold && !hold_done && ops_queued - first > beats / 2) begin
            hold_orders++;
            hold_done = 1'b1;
         end
         queue_session();
      end
   endtask

   task automatic wait_drained();
      while (pending_ops.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Appends, reads and unused kinds before any run is started.
      queue_op(KIND_APPEND, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, 0);
      queue_op(KIND_APPEND, 32'h0000_0000, 32'h8000_0000, 7, 255);
      queue_op(KIND_READ_CUR, $urandom, $urandom, 7, 1);
      queue_op(KIND_READ_CUR, $urandom, $urandom, 0, 2);
      queue_op(KIND_READ_RUN, $urandom, $urandom, 0, 0);
      queue_op(KIND_UNUSED_FIRST, $urandom, $urandom, 7, 255);
      queue_op(KIND_UNUSED_FIRST + 3'd1, $urandom, $urandom, 3, 1);
      queue_op(KIND_UNUSED_LAST, $urandom, $urandom, 0, 0);
      // First real run, extremes of the sample fields, a clear, then reads and a second run.
      queue_op(KIND_NEW_RUN, $urandom, $urandom, 5, 9);
      queue_op(KIND_READ_CUR, $urandom, $urandom, 0, 0);
      queue_op(KIND_APPEND, 32'h0000_0000, 32'h0000_0000, 0, 0);
      queue_op(KIND_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7, 255);
      queue_op(KIND_READ_CUR, $urandom, $urandom, 0, 255);
      queue_op(KIND_READ_RUN, $urandom, $urandom, 0, 1);
      queue_op(KIND_READ_RUN, $urandom, $urandom, 7, 0);
      queue_op(KIND_CLEAR, $urandom, $urandom, 2, 4);
      queue_op(KIND_READ_CUR, $urandom, $urandom, 0, 0);
      queue_op(KIND_READ_RUN, $urandom, $urandom, 0, 1);
      queue_op(KIND_APPEND, $urandom, $urandom, 1, 1);
      queue_op(KIND_READ_RUN, $urandom, $urandom, 0, 0);
      queue_op(KIND_READ_RUN, $urandom, $urandom, 0, 1);
      queue_op(KIND_NEW_RUN, $urandom, $urandom, 6, 200);
      queue_op(KIND_READ_RUN, $urandom, $urandom, 1, 0);
      gen_runs = 2;
      wait_drained();

      tx_idle_pct = 25;
      rx_idle_pct = 59;
      run_phase(PHASE_BEATS, 1'b1);
      wait_drained();

      tx_idle_pct = 59;
      rx_idle_pct = 25;
      run_phase(PHASE_BEATS, 1'b0);
      wait_drained();

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      run_phase(PHASE_BEATS, 1'b1);
      wait_drained();
      repeat (10) @(posedge clock);

      $display("Covered %0d beats: %0d new runs, %0d clears, %0d appends, %0d reads (%0d valid)",
               ops_queued, beats_by_kind[KIND_NEW_RUN], beats_by_kind[KIND_CLEAR],
               beats_by_kind[KIND_APPEND],
               beats_by_kind[KIND_READ_CUR] + beats_by_kind[KIND_READ_RUN], good_reads);
      $display("%0d appends to full runs, %0d runs into a full window, %0d results checked",
               full_rejects, window_reuses, results_checked);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule

>>> files.f
+incdir+rtl
rtl/wtss_pkg.sv
rtl/wtss_front.sv
rtl/wtss_queue.sv
rtl/wtss_back.sv
rtl/windowed_trial_sample_store.sv
bench/tb.sv
